// File: rtl/core/encoder_position_pid_homing_defines.svh
// Assertion macros for the checker file of the position loop.
`ifndef ENCODER_POSITION_PID_HOMING_DEFINES_SVH
`define ENCODER_POSITION_PID_HOMING_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EPPH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define EPPH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/epph_pkg.sv
// Types, constants and helper functions of the encoder position loop.
package epph_pkg;

	localparam int CNT_W   = 24;
	localparam int ERR_W   = CNT_W + 1;
	localparam int COEF_W  = 32;
	localparam int PROD_W  = COEF_W + ERR_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int DRV_W   = 40;
	localparam int FRAC_W  = 16;
	localparam int WIN_W   = 16;
	localparam int DIV_W   = 3;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [7:0] DUTY_LIMIT = 8'd254;
	localparam logic signed [DRV_W-1:0] DUTY_LIM_FX =
		$signed({{(DRV_W-FRAC_W-8){1'b0}}, DUTY_LIMIT, {FRAC_W{1'b0}}});
	localparam logic signed [DRV_W-1:0] DRV_MAX = {1'b0, {(DRV_W-1){1'b1}}};
	localparam logic signed [DRV_W-1:0] DRV_MIN = {1'b1, {(DRV_W-1){1'b0}}};

	// Item actions
	localparam logic [1:0] ACT_EDGE = 2'd0;
	localparam logic [1:0] ACT_TICK = 2'd1;
	localparam logic [1:0] ACT_SET  = 2'd2;

	// Bridge direction codes
	localparam logic [1:0] DIR_OFF = 2'd0;
	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_REV = 2'd2;

	// Multiplier operand selects
	localparam logic [1:0] MUL_NOW   = 2'd0;
	localparam logic [1:0] MUL_PREV  = 2'd1;
	localparam logic [1:0] MUL_PREV2 = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_COEF_NOW     = 3'd0;
	localparam logic [2:0] REG_COEF_PREV    = 3'd1;
	localparam logic [2:0] REG_COEF_PREV2   = 3'd2;
	localparam logic [2:0] REG_HOME_OFFSET  = 3'd3;
	localparam logic [2:0] REG_WINDOW_BELOW = 3'd4;
	localparam logic [2:0] REG_WINDOW_ABOVE = 3'd5;
	localparam logic [2:0] REG_DUTY_DIVISOR = 3'd6;
	localparam logic [2:0] REG_COUNT_INVERT = 3'd7;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_now;
		logic signed [COEF_W-1:0] coef_prev;
		logic signed [COEF_W-1:0] coef_prev2;
		logic signed [CNT_W-1:0]  home_offset;
		logic [WIN_W-1:0]         window_below;
		logic [WIN_W-1:0]         window_above;
		logic [DIV_W-1:0]         duty_divisor;
		logic                     count_invert;
	} epph_cfg_t;

	typedef struct packed {
		logic       item_load;
		logic       edge_step;
		logic       goal_load;
		logic       home_step;
		logic       err_step;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       acc_init;
		logic       acc_add;
		logic       sat_step;
		logic       duty_step;
		logic       out_load;
	} epph_cmd_t;

	// Integer part of the drive over the divisor, truncating; zero acts as one.
	// Divisors 3, 5, 6, 7 use a scaled reciprocal, exact for values up to 254.
	function automatic logic [7:0] duty_div(input logic [7:0] x, input logic [DIV_W-1:0] d);
		logic [17:0] p;
		logic [7:0]  r;
		p = '0;
		case (d)
			3'd2: r = x >> 1;
			3'd3: begin
				p = 18'(x) * 18'd171;
				r = 8'(p >> 9);
			end
			3'd4: r = x >> 2;
			3'd5: begin
				p = 18'(x) * 18'd205;
				r = 8'(p >> 10);
			end
			3'd6: begin
				p = 18'(x >> 1) * 18'd171;
				r = 8'(p >> 9);
			end
			3'd7: begin
				p = 18'(x) * 18'd293;
				r = 8'(p >> 11);
			end
			default: r = x;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/epph_regs.sv
// Register bank of the position loop behind the bus port.
module epph_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [epph_pkg::ADDR_W-1:0]  paddr,
	input  logic [epph_pkg::DATA_W-1:0]  pwdata,
	output logic [epph_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output epph_pkg::epph_cfg_t          cfg
);
	import epph_pkg::*;

	epph_cfg_t cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Take a write beat in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_now     <= '0;
			cfg_q.coef_prev    <= '0;
			cfg_q.coef_prev2   <= '0;
			cfg_q.home_offset  <= '0;
			cfg_q.window_below <= '0;
			cfg_q.window_above <= '0;
			cfg_q.duty_divisor <= DIV_W'(4);
			cfg_q.count_invert <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_COEF_NOW:     cfg_q.coef_now     <= pwdata;
				REG_COEF_PREV:    cfg_q.coef_prev    <= pwdata;
				REG_COEF_PREV2:   cfg_q.coef_prev2   <= pwdata;
				REG_HOME_OFFSET:  cfg_q.home_offset  <= pwdata[CNT_W-1:0];
				REG_WINDOW_BELOW: cfg_q.window_below <= pwdata[WIN_W-1:0];
				REG_WINDOW_ABOVE: cfg_q.window_above <= pwdata[WIN_W-1:0];
				REG_DUTY_DIVISOR: cfg_q.duty_divisor <= pwdata[DIV_W-1:0];
				REG_COUNT_INVERT: cfg_q.count_invert <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_COEF_NOW:     prdata = cfg_q.coef_now;
			REG_COEF_PREV:    prdata = cfg_q.coef_prev;
			REG_COEF_PREV2:   prdata = cfg_q.coef_prev2;
			REG_HOME_OFFSET:  prdata = DATA_W'(unsigned'(cfg_q.home_offset));
			REG_WINDOW_BELOW: prdata = DATA_W'(cfg_q.window_below);
			REG_WINDOW_ABOVE: prdata = DATA_W'(cfg_q.window_above);
			REG_DUTY_DIVISOR: prdata = DATA_W'(cfg_q.duty_divisor);
			REG_COUNT_INVERT: prdata = DATA_W'(cfg_q.count_invert);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/epph_ctrl.sv
// Sequencer of the position loop: item intake, tick steps and result hand-off.
module epph_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	output logic                 out_valid,
	input  logic                 out_stall,
	output epph_pkg::epph_cmd_t  cmd
);
	import epph_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_HOME = 4'd1;
	localparam logic [3:0] ST_ERR  = 4'd2;
	localparam logic [3:0] ST_MUL0 = 4'd3;
	localparam logic [3:0] ST_MUL1 = 4'd4;
	localparam logic [3:0] ST_MUL2 = 4'd5;
	localparam logic [3:0] ST_SUM  = 4'd6;
	localparam logic [3:0] ST_SAT  = 4'd7;
	localparam logic [3:0] ST_DUTY = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0] state_q, state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Next state and commands
	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		cmd.mul_sel = MUL_NOW;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					cmd.edge_step = (action == ACT_EDGE);
					cmd.goal_load = (action == ACT_SET);
					state_nxt     = (action == ACT_TICK) ? ST_HOME : ST_DONE;
				end
			end
			ST_HOME: begin
				cmd.home_step = 1'b1;
				state_nxt     = ST_ERR;
			end
			ST_ERR: begin
				cmd.err_step = 1'b1;
				state_nxt    = ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_NOW;
				cmd.acc_init = 1'b1;
				state_nxt    = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PREV;
				cmd.acc_add = 1'b1;
				state_nxt   = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PREV2;
				cmd.acc_add = 1'b1;
				state_nxt   = ST_SUM;
			end
			ST_SUM: begin
				cmd.acc_add = 1'b1;
				state_nxt   = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat_step = 1'b1;
				state_nxt    = ST_DUTY;
			end
			ST_DUTY: begin
				cmd.duty_step = 1'b1;
				state_nxt     = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Advance state; hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/epph_dp.sv
// Datapath of the position loop: count, homing, shared multiplier, drive and duty.
module epph_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  epph_pkg::epph_cmd_t                cmd,
	input  epph_pkg::epph_cfg_t                cfg,
	input  logic                               dir_level,
	input  logic                               home_sensor,
	input  logic signed [epph_pkg::CNT_W-1:0]  target,
	output logic [7:0]                         duty,
	output logic [1:0]                         drive_dir,
	output logic                               homing,
	output logic signed [epph_pkg::CNT_W-1:0]  position
);
	import epph_pkg::*;

	// Loop state
	logic signed [CNT_W-1:0]  edge_q, tick_pos_q, goal_q;
	logic signed [ERR_W-1:0]  err_last_q, err_older_q;
	logic signed [DRV_W-1:0]  drive_q;
	logic                     homing_q;
	logic [7:0]               duty_q;
	logic [1:0]               dir_q;
	logic                     sensor_q;

	// Working registers
	logic signed [ERR_W-1:0]  e_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	// Result registers
	logic [7:0]               out_duty_q;
	logic [1:0]               out_dir_q;
	logic                     out_homing_q;
	logic signed [CNT_W-1:0]  out_pos_q;

	logic                     start;
	logic signed [CNT_W+1:0]  g_w, p_w, lo_w, hi_w;
	logic                     in_win;
	logic signed [COEF_W-1:0] mul_c;
	logic signed [ERR_W-1:0]  mul_e;
	logic signed [DRV_W-1:0]  drv_sat, drv_clamp;
	logic [DRV_W-1:0]         mag;
	logic [7:0]               mag_int;

	// Homing window test against the home target
	always_comb begin
		start  = sensor_q && !homing_q;
		g_w    = (CNT_W+2)'(cfg.home_offset);
		p_w    = start ? '0 : (CNT_W+2)'(tick_pos_q);
		lo_w   = g_w - $signed({2'b00, {(CNT_W-WIN_W){1'b0}}, cfg.window_below});
		hi_w   = g_w + $signed({2'b00, {(CNT_W-WIN_W){1'b0}}, cfg.window_above});
		in_win = (p_w > lo_w) && (p_w < hi_w);
	end

	// Multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MUL_PREV: begin
				mul_c = cfg.coef_prev;
				mul_e = err_last_q;
			end
			MUL_PREV2: begin
				mul_c = cfg.coef_prev2;
				mul_e = err_older_q;
			end
			default: begin
				mul_c = cfg.coef_now;
				mul_e = e_q;
			end
		endcase
	end

	// Saturate the sum to the drive width
	always_comb begin
		if (acc_q[ACC_W-1:DRV_W-1] == {(ACC_W-DRV_W+1){acc_q[ACC_W-1]}})
			drv_sat = acc_q[DRV_W-1:0];
		else if (acc_q[ACC_W-1])
			drv_sat = DRV_MIN;
		else
			drv_sat = DRV_MAX;
	end

	// Clamp the drive and take its integer magnitude
	always_comb begin
		if (drive_q > DUTY_LIM_FX)
			drv_clamp = DUTY_LIM_FX;
		else if (drive_q < -DUTY_LIM_FX)
			drv_clamp = -DUTY_LIM_FX;
		else
			drv_clamp = drive_q;
		mag     = drv_clamp[DRV_W-1] ? unsigned'(-drv_clamp) : unsigned'(drv_clamp);
		mag_int = mag[FRAC_W+7:FRAC_W];
	end

	// Loop state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q      <= '0;
			tick_pos_q  <= '0;
			goal_q      <= '0;
			err_last_q  <= '0;
			err_older_q <= '0;
			drive_q     <= '0;
			homing_q    <= 1'b0;
			duty_q      <= '0;
			dir_q       <= DIR_OFF;
		end else begin
			if (cmd.edge_step) begin
				if (dir_level != cfg.count_invert)
					edge_q <= edge_q - CNT_W'(1);
				else
					edge_q <= edge_q + CNT_W'(1);
			end
			if (cmd.goal_load)
				goal_q <= target;
			if (cmd.home_step && (start || homing_q)) begin
				if (in_win) begin
					edge_q     <= '0;
					tick_pos_q <= '0;
					goal_q     <= '0;
					homing_q   <= 1'b0;
				end else begin
					goal_q   <= cfg.home_offset;
					homing_q <= 1'b1;
					if (start) begin
						edge_q     <= '0;
						tick_pos_q <= '0;
					end
				end
			end
			if (cmd.err_step)
				tick_pos_q <= edge_q;
			if (cmd.sat_step) begin
				drive_q     <= drv_sat;
				err_older_q <= err_last_q;
				err_last_q  <= e_q;
			end
			if (cmd.duty_step) begin
				if (drv_clamp > 0) begin
					dir_q  <= DIR_FWD;
					duty_q <= duty_div(mag_int, cfg.duty_divisor);
				end else if (drv_clamp < 0) begin
					dir_q  <= DIR_REV;
					duty_q <= duty_div(mag_int, cfg.duty_divisor);
				end else begin
					dir_q  <= DIR_OFF;
					duty_q <= '0;
				end
			end
		end
	end

	// Error, product, accumulator and result beat
	always_ff @(posedge clk) begin
		if (cmd.item_load)
			sensor_q <= home_sensor;
		if (cmd.err_step)
			e_q <= ERR_W'(goal_q) - ERR_W'(edge_q);
		if (cmd.mul_en)
			prod_s1 <= mul_c * mul_e;
		if (cmd.acc_init)
			acc_q <= ACC_W'(drive_q);
		else if (cmd.acc_add)
			acc_q <= acc_q + ACC_W'(prod_s1);
		if (cmd.out_load) begin
			out_duty_q   <= duty_q;
			out_dir_q    <= dir_q;
			out_homing_q <= homing_q;
			out_pos_q    <= edge_q;
		end
	end

	assign duty      = out_duty_q;
	assign drive_dir = out_dir_q;
	assign homing    = out_homing_q;
	assign position  = out_pos_q;

endmodule

// File: rtl/core/encoder_position_pid_homing.sv
// Single-axis encoder position loop with homing and incremental PID.
//
// Input channel (in_valid / in_stall): one beat per item; action selects an
// encoder edge (dir_level), a control tick (home_sensor) or a new target.
// Output channel (out_valid / out_stall): exactly one result beat per item
// with the duty and bridge direction of the latest tick, the homing flag and
// the encoder count after the item.
// Configuration: bus port, register i at byte address 4*i, writes while idle.
// Items are taken one at a time. Edge, set-target and unused items go from
// intake straight to the result step. A tick walks the sequencer through
// homing, error, three products on the one 32x25 multiplier, sum, saturation
// and duty before its result step. The next item is taken only once the
// result of the previous one is loaded and the sequencer is back in idle.
// While out_stall holds a result, the sequencer finishes the next item and
// waits in its last step; in_stall stays high until that result is loaded.
// Reset clears the count, target, errors, drive and homing flag, loads the
// registers with their defaults (duty divisor 4) and leaves both channels
// empty.
module encoder_position_pid_homing (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         action,
	input  logic                               dir_level,
	input  logic                               home_sensor,
	input  logic signed [epph_pkg::CNT_W-1:0]  target,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [7:0]                         duty,
	output logic [1:0]                         drive_dir,
	output logic                               homing,
	output logic signed [epph_pkg::CNT_W-1:0]  position,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [epph_pkg::ADDR_W-1:0]        paddr,
	input  logic [epph_pkg::DATA_W-1:0]        pwdata,
	output logic [epph_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import epph_pkg::*;

	epph_cfg_t cfg;
	epph_cmd_t cmd;

	epph_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	epph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	epph_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.dir_level   (dir_level),
		.home_sensor (home_sensor),
		.target      (target),
		.duty        (duty),
		.drive_dir   (drive_dir),
		.homing      (homing),
		.position    (position)
	);

endmodule

// File: rtl/core/epph_checker.sv
// Port-level checks of the position loop and their binding to the top level.
`include "encoder_position_pid_homing_defines.svh"

module epph_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [7:0]                         duty,
	input  logic [1:0]                         drive_dir,
	input  logic                               homing,
	input  logic signed [epph_pkg::CNT_W-1:0]  position
);
	import epph_pkg::*;

	// A stalled result beat stays and holds its payload
	`EPPH_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(duty) && $stable(drive_dir) && $stable(homing) && $stable(position), "stalled result beat changed")

	// One item at a time: the input stalls right after a beat is taken
	`EPPH_ASSERT_NXT(a_one_item, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while an item is in flight")

	// A bridge that is off carries no duty
	`EPPH_ASSERT_IMP(a_off_no_duty, clk, arst_n, out_valid && (drive_dir == DIR_OFF), duty == 8'd0, "duty set with bridge off")

	// Duty never passes the drive limit
	`EPPH_ASSERT_IMP(a_duty_limit, clk, arst_n, out_valid, duty <= DUTY_LIMIT, "duty above limit")

endmodule

bind encoder_position_pid_homing epph_checker u_epph_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.duty      (duty),
	.drive_dir (drive_dir),
	.homing    (homing),
	.position  (position)
);

// File: dv/tb.sv
// Self-checking testbench for the single-axis encoder position loop with homing.
`timescale 1ns / 1ps

module tb;
	import epph_pkg::*;

	localparam int NUM_SETTINGS = 9;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		logic [1:0]              act;
		logic                    lvl;
		logic                    sensor;
		logic signed [CNT_W-1:0] tgt;
	} loop_cmd_t;

	typedef struct {
		logic [7:0]              duty;
		logic [1:0]              dir;
		logic                    homing;
		logic signed [CNT_W-1:0] pos;
	} loop_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_EDGE;
	logic dir_level = 1'b0;
	logic home_sensor = 1'b0;
	logic signed [CNT_W-1:0] target = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] duty;
	logic [1:0] drive_dir;
	logic homing;
	logic signed [CNT_W-1:0] position;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	encoder_position_pid_homing dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .dir_level(dir_level), .home_sensor(home_sensor), .target(target),
		.out_valid(out_valid), .out_stall(out_stall),
		.duty(duty), .drive_dir(drive_dir), .homing(homing), .position(position),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Loop state as seen by the predictor
	logic signed [CNT_W-1:0] count_m = '0;
	logic signed [CNT_W-1:0] seen_m = '0;
	logic signed [CNT_W-1:0] goal_m = '0;
	longint err1_m = 0;
	longint err2_m = 0;
	longint drive_m = 0;
	logic homing_m = 1'b0;
	logic [7:0] duty_m = '0;
	logic [1:0] dir_m = DIR_OFF;

	// Register copy, reset values
	longint k_now = 0;
	longint k_prev = 0;
	longint k_prev2 = 0;
	logic signed [CNT_W-1:0] home_off = '0;
	logic [WIN_W-1:0] win_lo = '0;
	logic [WIN_W-1:0] win_hi = '0;
	logic [DIV_W-1:0] div_r = 3'd4;
	logic inv_r = 1'b0;

	loop_cmd_t queued_commands[$];
	loop_out_t loop_outputs_due[$];

	logic beat_taken = 1'b0;
	logic hold_off = 1'b0;
	int send_idle_pct = 27;
	int recv_idle_pct = 65;
	int fail_count = 0;
	int made_items = 0;
	int items_taken = 0;
	int results_seen = 0;
	int ticks_run = 0;
	int homes_done = 0;
	int sat_hits = 0;

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= 30)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// One item through the position loop: edge, tick, new target or nothing
	function automatic loop_out_t step_position_loop(loop_cmd_t c);
		longint e, g, p, total, clip, lim, mag, dv;
		loop_out_t o;
		case (c.act)
			ACT_EDGE: begin
				if (c.lvl != inv_r)
					count_m = count_m - CNT_W'(1);
				else
					count_m = count_m + CNT_W'(1);
			end
			ACT_TICK: begin
				ticks_run++;
				// homing: sensor starts it, reaching the window ends it
				if (c.sensor && !homing_m) begin
					count_m = '0;
					seen_m = '0;
					goal_m = '0;
					homing_m = 1'b1;
				end
				if (homing_m) begin
					goal_m = home_off;
					g = longint'(goal_m);
					p = longint'(seen_m);
					if (p > g - longint'(win_lo) && p < g + longint'(win_hi)) begin
						count_m = '0;
						seen_m = '0;
						goal_m = '0;
						homing_m = 1'b0;
						homes_done++;
					end
				end
				// incremental PID step, saturating at the drive width
				seen_m = count_m;
				e = longint'(goal_m) - longint'(seen_m);
				total = drive_m + k_now * e + k_prev * err1_m + k_prev2 * err2_m;
				if (total > longint'(DRV_MAX)) begin
					total = longint'(DRV_MAX);
					sat_hits++;
				end
				if (total < longint'(DRV_MIN)) begin
					total = longint'(DRV_MIN);
					sat_hits++;
				end
				drive_m = total;
				err2_m = err1_m;
				err1_m = e;
				// clamp and split into duty and direction
				lim = longint'(DUTY_LIM_FX);
				clip = drive_m;
				if (clip > lim)
					clip = lim;
				if (clip < -lim)
					clip = -lim;
				dv = (div_r == '0) ? 1 : longint'(div_r);
				mag = (clip < 0) ? -clip : clip;
				duty_m = 8'((mag >> FRAC_W) / dv);
				if (clip > 0)
					dir_m = DIR_FWD;
				else if (clip < 0)
					dir_m = DIR_REV;
				else begin
					dir_m = DIR_OFF;
					duty_m = '0;
				end
			end
			ACT_SET: goal_m = c.tgt;
			default: ;
		endcase
		o.duty = duty_m;
		o.dir = dir_m;
		o.homing = homing_m;
		o.pos = count_m;
		return o;
	endfunction

	// Register write over the bus, mirrored into the predictor
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COEF_NOW:     k_now = longint'($signed(val));
			REG_COEF_PREV:    k_prev = longint'($signed(val));
			REG_COEF_PREV2:   k_prev2 = longint'($signed(val));
			REG_HOME_OFFSET:  home_off = val[CNT_W-1:0];
			REG_WINDOW_BELOW: win_lo = val[WIN_W-1:0];
			REG_WINDOW_ABOVE: win_hi = val[WIN_W-1:0];
			REG_DUTY_DIVISOR: div_r = val[DIV_W-1:0];
			REG_COUNT_INVERT: inv_r = val[0];
			default: ;
		endcase
	endtask

	function automatic logic any_bit();
		return 1'($urandom);
	endfunction

	function automatic logic [CNT_W-1:0] any_count();
		return 24'($urandom);
	endfunction

	task automatic queue_item(logic [1:0] a, logic l, logic s, logic [CNT_W-1:0] t);
		loop_cmd_t c;
		c.act = a;
		c.lvl = l;
		c.sensor = s;
		c.tgt = t;
		queued_commands.push_back(c);
		if (a != ACT_NONE)
			made_items++;
	endtask

	// Sensor hit, then edges walking toward the home target, then ticks
	task automatic queue_homing_run();
		int span, steps, k;
		logic up_lvl;
		span = home_off;
		if (span > 60)
			span = 60;
		if (span < -60)
			span = -60;
		up_lvl = inv_r;
		queue_item(ACT_TICK, any_bit(), 1'b1, any_count());
		steps = ((span < 0) ? -span : span) + int'($urandom_range(0, 6)) - 3;
		for (k = 0; k < steps; k++) begin
			queue_item(ACT_EDGE, (span < 0) ? ~up_lvl : up_lvl, any_bit(), any_count());
			if ($urandom_range(0, 15) == 0)
				queue_item(ACT_TICK, any_bit(), 1'b0, any_count());
		end
		if ($urandom_range(0, 9) == 0)
			queue_item(ACT_SET, any_bit(), any_bit(), any_count());
		repeat ($urandom_range(1, 3))
			queue_item(ACT_TICK, any_bit(), 1'b0, any_count());
	endtask

	// New target near zero, then a mix of edges and ticks
	task automatic queue_move_run();
		logic [CNT_W-1:0] t;
		t = 24'($urandom_range(0, 400)) - 24'd200;
		queue_item(ACT_SET, any_bit(), any_bit(), t);
		repeat ($urandom_range(6, 16)) begin
			if ($urandom_range(0, 2) == 0)
				queue_item(ACT_TICK, any_bit(), $urandom_range(0, 19) == 0, any_count());
			else
				queue_item(ACT_EDGE, any_bit(), any_bit(), any_count());
		end
	endtask

	task automatic queue_random(int n);
		int stop_at, pick;
		stop_at = made_items + n;
		while (made_items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				queue_homing_run();
			else if (pick < 80)
				queue_move_run();
			else
				queue_item(2'($urandom_range(0, 3)), any_bit(), any_bit(), any_count());
		end
	endtask

	// Short hand-picked sequences for the first settings
	task automatic queue_directed(int p);
		case (p)
			0: begin
				queue_item(ACT_EDGE, 1'b0, 1'b0, '0);
				queue_item(ACT_EDGE, 1'b1, 1'b1, '0);
				queue_item(ACT_EDGE, 1'b1, 1'b0, '0);
				queue_item(ACT_NONE, 1'b1, 1'b1, 24'h7FFFFF);
				queue_item(ACT_SET, 1'b0, 1'b0, 24'h7FFFFF);
				queue_item(ACT_SET, 1'b1, 1'b1, 24'h800000);
				queue_item(ACT_TICK, 1'b0, 1'b0, '0);
				queue_item(ACT_TICK, 1'b1, 1'b1, 24'hFFFFFF);
				queue_item(ACT_TICK, 1'b0, 1'b0, '0);
			end
			1: begin
				queue_item(ACT_TICK, 1'b0, 1'b0, '0);
				repeat (4) queue_item(ACT_EDGE, 1'b0, 1'b0, '0);
				queue_item(ACT_TICK, 1'b0, 1'b0, '0);
				queue_item(ACT_SET, 1'b0, 1'b0, 24'd300);
				queue_item(ACT_TICK, 1'b0, 1'b0, '0);
				queue_item(ACT_SET, 1'b0, 1'b0, -24'sd300);
				queue_item(ACT_TICK, 1'b0, 1'b0, '0);
			end
			2: begin
				queue_item(ACT_SET, 1'b0, 1'b0, 24'h7FFFFF);
				queue_item(ACT_TICK, 1'b0, 1'b0, '0);
				queue_item(ACT_SET, 1'b0, 1'b0, 24'h800000);
				queue_item(ACT_TICK, 1'b0, 1'b0, '0);
				queue_item(ACT_EDGE, 1'b1, 1'b0, '0);
				queue_item(ACT_EDGE, 1'b0, 1'b0, '0);
				queue_item(ACT_TICK, 1'b0, 1'b1, '0);
			end
			3: begin
				queue_item(ACT_TICK, 1'b0, 1'b0, '0);
				queue_item(ACT_TICK, 1'b0, 1'b1, '0);
				queue_item(ACT_TICK, 1'b1, 1'b0, '0);
			end
			default: ;
		endcase
	endtask

	// Register settings: a plain loop, two sets of extremes, then random ones
	task automatic load_setting(int p);
		logic [31:0] v [8];
		int i;
		case (p)
			1: begin
				v[REG_COEF_NOW] = 32'h0001_0000;
				v[REG_COEF_PREV] = 32'hFFFF_8000;
				v[REG_COEF_PREV2] = 32'h0000_2000;
				v[REG_HOME_OFFSET] = 32'd5;
				v[REG_WINDOW_BELOW] = 32'd3;
				v[REG_WINDOW_ABOVE] = 32'd3;
				v[REG_DUTY_DIVISOR] = 32'd1;
				v[REG_COUNT_INVERT] = 32'd0;
			end
			2: begin
				v[REG_COEF_NOW] = 32'h7FFF_FFFF;
				v[REG_COEF_PREV] = 32'h8000_0000;
				v[REG_COEF_PREV2] = 32'h7FFF_FFFF;
				v[REG_HOME_OFFSET] = 32'h007F_FFFF;
				v[REG_WINDOW_BELOW] = 32'h0000_FFFF;
				v[REG_WINDOW_ABOVE] = 32'd0;
				v[REG_DUTY_DIVISOR] = 32'd0;
				v[REG_COUNT_INVERT] = 32'd1;
			end
			3: begin
				v[REG_COEF_NOW] = 32'h8000_0000;
				v[REG_COEF_PREV] = 32'h7FFF_FFFF;
				v[REG_COEF_PREV2] = 32'h8000_0000;
				v[REG_HOME_OFFSET] = 32'hFF80_0000;
				v[REG_WINDOW_BELOW] = 32'd0;
				v[REG_WINDOW_ABOVE] = 32'h0000_FFFF;
				v[REG_DUTY_DIVISOR] = 32'd7;
				v[REG_COUNT_INVERT] = 32'd1;
			end
			default: begin
				for (i = 0; i < 3; i++)
					v[i] = (p == NUM_SETTINGS - 1) ? $urandom
						: 32'($urandom_range(0, 32'h80000)) - 32'h40000;
				v[REG_HOME_OFFSET] = 32'($urandom_range(0, 120)) - 32'd60;
				v[REG_WINDOW_BELOW] = $urandom_range(0, 12);
				v[REG_WINDOW_ABOVE] = $urandom_range(0, 12);
				v[REG_DUTY_DIVISOR] = (p == 4) ? 32'd3 : (p == 5) ? 32'd5
					: (p == 6) ? 32'd6 : (p == 7) ? 32'd2 : 32'd4;
				v[REG_COUNT_INVERT] = $urandom_range(0, 1);
			end
		endcase
		for (i = 0; i < 8; i++)
			write_reg(3'(i), v[i]);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (queued_commands.size() != 0 || in_valid || loop_outputs_due.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	// Take accepted input beats and predict their results
	always @(posedge clk) begin : take_beats
		loop_cmd_t c;
		beat_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			c.act = action;
			c.lvl = dir_level;
			c.sensor = home_sensor;
			c.tgt = target;
			loop_outputs_due.push_back(step_position_loop(c));
			items_taken++;
		end
	end

	// Offer the next queued item, with random gaps
	always @(negedge clk) begin : drive_items
		loop_cmd_t nxt;
		if (!arst_n)
			in_valid <= 1'b0;
		else if (!in_valid || beat_taken) begin
			if (queued_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = queued_commands.pop_front();
				in_valid <= 1'b1;
				action <= nxt.act;
				dir_level <= nxt.lvl;
				home_sensor <= nxt.sensor;
				target <= nxt.tgt;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random, or hard during the hold-off
	always @(negedge clk) begin
		out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_results
		loop_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (loop_outputs_due.size() == 0) begin
				report_mismatch("result beat with no prediction pending");
			end else begin
				want = loop_outputs_due.pop_front();
				results_seen++;
				if (duty !== want.duty)
					report_mismatch($sformatf("duty %0d, predicted %0d", duty, want.duty));
				if (drive_dir !== want.dir)
					report_mismatch($sformatf("drive_dir %0d, predicted %0d",
						drive_dir, want.dir));
				if (homing !== want.homing)
					report_mismatch($sformatf("homing %0b, predicted %0b", homing, want.homing));
				if (position !== want.pos)
					report_mismatch($sformatf("position %0d, predicted %0d",
						position, want.pos));
			end
		end
	end

	// Hold the result side off for a long stretch while items keep coming
	initial begin : long_hold_off
		do @(posedge clk);
		while (items_taken < 700 || queued_commands.size() < 40);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Timed out with %0d results outstanding", loop_outputs_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Walk through the register settings, directed items first, then random
	initial begin : run_settings
		int p;
		for (p = 0; p < NUM_SETTINGS; p++) begin
			if (p == 0) begin
				repeat (7) @(negedge clk);
				arst_n <= 1'b1;
				@(posedge clk);
			end else begin
				wait_idle();
				load_setting(p);
				@(posedge clk);
			end
			case (p / 3)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 65;
				end
				1: begin
					send_idle_pct = 65;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			queue_directed(p);
			queue_random((p == 0) ? 80 : 190);
		end
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Covered %0d items and %0d results over %0d register settings",
			items_taken, results_seen, NUM_SETTINGS);
		$display("  %0d control ticks, %0d homing moves completed, %0d drive saturations",
			ticks_run, homes_done, sat_hits);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
